// File: rtl/ldisp_pkg.sv
// Loop iteration dispatcher: shared types, codes, widths and a helper function.
// No dependencies; used by the dispatcher core and the divider.
package ldisp_pkg;

  localparam int unsigned MaxWorkersDef = 128;
  localparam int unsigned IdxW   = 32;
  localparam int unsigned DivDW  = 33;
  localparam int unsigned DivVW  = 16;
  localparam int unsigned MulW   = 49;
  localparam int unsigned EntW   = 2 * IdxW + 1;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    SRC_OWN    = 3'd0,
    SRC_NEW    = 3'd1,
    SRC_STOLEN = 3'd2,
    SRC_NONE   = 3'd3,
    SRC_BAD    = 3'd4,
    SRC_BEGUN  = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_DYNAMIC = 2'd1,
    MODE_GUIDED  = 2'd2,
    MODE_AUTO    = 2'd3
  } mode_e;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CHUNK  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COUNT  = 3'd5;

  typedef struct packed {
    logic            busy;
    logic [IdxW-1:0] fin;
    logic [IdxW-1:0] nxt;
  } entry_t;

  function automatic logic [IdxW-1:0] clip_add(input logic [IdxW-1:0] base,
                                               input logic [MulW-1:0] add,
                                               input logic [IdxW-1:0] lim);
    logic [MulW:0] s;
    s = (MulW+1)'(base) + (MulW+1)'(add);
    clip_add = (s > (MulW+1)'(lim)) ? lim : s[IdxW-1:0];
  endfunction

endpackage

// File: rtl/loop_iteration_dispatcher_core.sv
// Next from own chunk uses no divider, nor does a dynamic new chunk; a guided or auto
// new chunk is set by two divider passes. Steal: a scan over every worker, with a
// divider pass per worker that beats the best so far. Begin: total-count division, then
// an entry sweep; static with chunk 0 adds a chunk division; an empty range skips the total.
// One item in flight; a new item enters while the previous result waits. Reset clears
// control state; worker table reads as empty until the first begin.
module loop_iteration_dispatcher_core #(
  parameter int unsigned MAX_WORKERS = ldisp_pkg::MaxWorkersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [6:0]  worker_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic [31:0] loop_index_o,
  output logic [2:0]  source_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned MW   = ldisp_pkg::MulW;
  localparam int unsigned DW   = ldisp_pkg::DivDW;
  localparam int unsigned VW   = ldisp_pkg::DivVW;
  localparam int unsigned EW   = ldisp_pkg::EntW;

  typedef enum logic [4:0] {
    S_IDLE, S_BEG, S_TOT_WAIT, S_BEG2, S_SCH_WAIT, S_SMUL, S_SWEEP,
    S_EVAL, S_REM_WAIT, S_GSEL, S_GDIV_WAIT, S_CMUL, S_TAKE,
    S_SCAN_RD, S_SCAN_EV, S_ITEMS_WAIT, S_THR,
    S_VIC_RD, S_VIC_EV, S_KMUL, S_VIC_WR, S_GIVE, S_DONE
  } state_e;

  state_e state_q;

  logic [31:0] cfg_first_q, cfg_limit_q;
  logic [15:0] cfg_stride_q, cfg_chunk_q;
  logic [1:0]  cfg_mode_q;
  logic [7:0]  cfg_count_q;

  logic [31:0]       lt_first_q, lt_limit_q;
  logic [15:0]       lt_stride_q, lt_chunk_q;
  ldisp_pkg::mode_e  lt_mode_q;
  logic [CntW-1:0]   lt_count_q;
  logic [CntW-1:0]   count_sat;
  logic [7:0]        count_raw;

  logic [31:0] cursor_q, total_q, rem_q, chunk_q, most_q;
  logic [31:0] gstart_q, gend_q, vnext_q, vend_q, res_idx_q;
  logic        begun_q, found_q;
  logic [AW-1:0]   w_q, best_q;
  logic [CntW-1:0] idx_q;
  logic [33:0]     sacc_q;
  logic [MW-1:0]   mul_q, thr_q;
  logic [32:0]     mul_a;
  ldisp_pkg::src_e res_src_q;

  logic              mem_we_q;
  logic [AW-1:0]     mem_waddr_q;
  ldisp_pkg::entry_t mem_wdata_q;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  ldisp_pkg::entry_t ent;

  logic          div_start_q, div_done;
  logic [DW-1:0] div_dividend_q, div_quot;
  logic [VW-1:0] div_divisor_q;

  logic            out_valid_q, out_granted_q;
  logic [31:0]     out_index_q;
  ldisp_pkg::src_e out_src_q;

  logic [MW:0]  sw_sum;
  logic [31:0]  sw_st, sw_en;
  logic [33:0]  sw_next;
  logic [34:0]  rem35, tot35;
  logic [3:0]   gdiv;
  logic [31:0]  g_chunk;
  logic [31:0]  keep;
  logic [33:0]  most3;
  logic [31:0]  diff;
  logic         cand;

  ldisp_ram #(.Width(EW), .Depth(MAX_WORKERS)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we_q),
    .waddr_i (mem_waddr_q),
    .wdata_i (mem_wdata_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ldisp_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign ent = begun_q ? ldisp_pkg::entry_t'(ram_rdata) : '0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(worker_i);
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q[AW-1:0];
      end
      S_VIC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = best_q;
      end
      default: ;
    endcase
  end

  assign count_raw = (cfg_count_q == 8'd0) ? 8'd1 : cfg_count_q;
  assign count_sat = (32'(count_raw) > MAX_WORKERS) ? CntW'(MAX_WORKERS) : CntW'(count_raw);

  assign sw_sum  = (MW+1)'(sacc_q) + (MW+1)'(mul_q);
  assign sw_st   = (sacc_q > 34'(lt_limit_q)) ? lt_limit_q : sacc_q[31:0];
  assign sw_en   = (sw_sum > (MW+1)'(lt_limit_q)) ? lt_limit_q : sw_sum[31:0];
  assign sw_next = (sw_sum >= (MW+1)'(34'h2_0000_0000)) ? 34'h2_0000_0000 : sw_sum[33:0];

  assign rem35 = 35'(rem_q);
  assign tot35 = 35'(total_q);
  always_comb begin
    if ((rem35 << 2) > tot35 * 35'd3) begin
      gdiv = 4'd2;
    end else if ((rem35 << 1) > tot35) begin
      gdiv = 4'd3;
    end else if ((rem35 << 2) > tot35) begin
      gdiv = 4'd4;
    end else begin
      gdiv = 4'd8;
    end
  end

  always_comb begin
    g_chunk = (div_quot == '0) ? 32'd1 : div_quot[31:0];
    if (lt_chunk_q != 16'd0 && g_chunk > 32'(lt_chunk_q)) begin
      g_chunk = 32'(lt_chunk_q);
    end
    if (rem35 < (35'(lt_count_q) << 2)) begin
      g_chunk = 32'd1;
    end
  end

  assign most3 = 34'(most_q) * 34'd3;
  always_comb begin
    if (most_q > 32'd100) begin
      keep = most3[33:2];
    end else if (most_q > 32'd10) begin
      keep = most_q >> 1;
    end else begin
      keep = 32'd1;
    end
  end

  assign diff = ent.fin - ent.nxt;
  assign cand = (idx_q[AW-1:0] != w_q) && ent.busy && (ent.nxt < ent.fin);
  assign mul_a = (state_q == S_THR) ? 33'(most_q) + 33'd1 : 33'(chunk_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_SMUL || state_q == S_CMUL || state_q == S_THR || state_q == S_KMUL) begin
      mul_q <= MW'(mul_a) * MW'(lt_stride_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_first_q  <= '0;
      cfg_limit_q  <= '0;
      cfg_stride_q <= 16'd1;
      cfg_mode_q   <= '0;
      cfg_chunk_q  <= '0;
      cfg_count_q  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ldisp_pkg::CFG_FIRST:  cfg_first_q  <= cfg_data_i;
        ldisp_pkg::CFG_LIMIT:  cfg_limit_q  <= cfg_data_i;
        ldisp_pkg::CFG_STRIDE: cfg_stride_q <= cfg_data_i[15:0];
        ldisp_pkg::CFG_MODE:   cfg_mode_q   <= cfg_data_i[1:0];
        ldisp_pkg::CFG_CHUNK:  cfg_chunk_q  <= cfg_data_i[15:0];
        ldisp_pkg::CFG_COUNT:  cfg_count_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lt_first_q  <= '0;
      lt_limit_q  <= '0;
      lt_stride_q <= 16'd1;
      lt_mode_q   <= ldisp_pkg::MODE_STATIC;
      lt_chunk_q  <= '0;
      lt_count_q  <= CntW'(1);
      cursor_q    <= '0;
      total_q     <= '0;
      begun_q     <= 1'b0;
      mem_we_q    <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mem_we_q    <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            w_q <= AW'(worker_i);
            if (operation_i == ldisp_pkg::OP_BEGIN) begin
              lt_first_q  <= cfg_first_q;
              lt_limit_q  <= cfg_limit_q;
              lt_stride_q <= (cfg_stride_q == 16'd0) ? 16'd1 : cfg_stride_q;
              lt_mode_q   <= ldisp_pkg::mode_e'(cfg_mode_q);
              lt_chunk_q  <= cfg_chunk_q;
              lt_count_q  <= count_sat;
              state_q     <= S_BEG;
            end else if (32'(worker_i) >= 32'(lt_count_q)) begin
              res_src_q <= ldisp_pkg::SRC_BAD;
              res_idx_q <= '0;
              state_q   <= S_DONE;
            end else begin
              state_q <= S_EVAL;
            end
          end
        end
        S_BEG: begin
          begun_q <= 1'b1;
          if (lt_limit_q > lt_first_q) begin
            div_start_q    <= 1'b1;
            div_dividend_q <= DW'(lt_limit_q - lt_first_q) + DW'(lt_stride_q) - DW'(1);
            div_divisor_q  <= lt_stride_q;
            state_q        <= S_TOT_WAIT;
          end else begin
            total_q <= '0;
            state_q <= S_BEG2;
          end
        end
        S_TOT_WAIT: begin
          if (div_done) begin
            total_q <= div_quot[31:0];
            state_q <= S_BEG2;
          end
        end
        S_BEG2: begin
          cursor_q <= lt_first_q;
          sacc_q   <= 34'(lt_first_q);
          idx_q    <= '0;
          if (lt_mode_q != ldisp_pkg::MODE_STATIC) begin
            state_q <= S_SWEEP;
          end else if (lt_chunk_q != 16'd0) begin
            chunk_q <= 32'(lt_chunk_q);
            state_q <= S_SMUL;
          end else begin
            div_start_q    <= 1'b1;
            div_dividend_q <= DW'(total_q) + DW'(lt_count_q) - DW'(1);
            div_divisor_q  <= VW'(lt_count_q);
            state_q        <= S_SCH_WAIT;
          end
        end
        S_SCH_WAIT: begin
          if (div_done) begin
            chunk_q <= div_quot[31:0];
            state_q <= S_SMUL;
          end
        end
        S_SMUL: begin
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (idx_q == lt_count_q) begin
            res_src_q <= ldisp_pkg::SRC_BEGUN;
            res_idx_q <= '0;
            state_q   <= S_DONE;
          end else begin
            mem_we_q    <= 1'b1;
            mem_waddr_q <= idx_q[AW-1:0];
            if (lt_mode_q == ldisp_pkg::MODE_STATIC) begin
              mem_wdata_q <= '{busy: (sw_st < sw_en), fin: sw_en, nxt: sw_st};
            end else begin
              mem_wdata_q <= '0;
            end
            sacc_q <= sw_next;
            idx_q  <= idx_q + 1'b1;
          end
        end
        S_EVAL: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= w_q;
          if (ent.nxt < ent.fin) begin
            mem_wdata_q <= '{busy: ent.busy,
                             fin: ent.fin,
                             nxt: ldisp_pkg::clip_add(ent.nxt, MW'(lt_stride_q), ent.fin)};
            res_idx_q   <= ent.nxt;
            res_src_q   <= ldisp_pkg::SRC_OWN;
            state_q     <= S_DONE;
          end else begin
            mem_wdata_q <= '{busy: 1'b0, fin: ent.fin, nxt: ent.nxt};
            idx_q       <= '0;
            found_q     <= 1'b0;
            most_q      <= 32'd1;
            thr_q       <= MW'(lt_stride_q) << 1;
            if (lt_mode_q != ldisp_pkg::MODE_STATIC && cursor_q < lt_limit_q) begin
              if (lt_mode_q == ldisp_pkg::MODE_DYNAMIC) begin
                chunk_q <= (lt_chunk_q == 16'd0) ? 32'd1 : 32'(lt_chunk_q);
                state_q <= S_CMUL;
              end else begin
                div_start_q    <= 1'b1;
                div_dividend_q <= DW'(lt_limit_q - cursor_q) + DW'(lt_stride_q) - DW'(1);
                div_divisor_q  <= lt_stride_q;
                state_q        <= S_REM_WAIT;
              end
            end else if (lt_mode_q == ldisp_pkg::MODE_AUTO) begin
              state_q <= S_SCAN_RD;
            end else begin
              res_idx_q <= '0;
              res_src_q <= ldisp_pkg::SRC_NONE;
              state_q   <= S_DONE;
            end
          end
        end
        S_REM_WAIT: begin
          if (div_done) begin
            rem_q   <= div_quot[31:0];
            state_q <= S_GSEL;
          end
        end
        S_GSEL: begin
          div_start_q    <= 1'b1;
          div_dividend_q <= DW'(rem_q);
          div_divisor_q  <= VW'(32'(lt_count_q) * 32'(gdiv));
          state_q        <= S_GDIV_WAIT;
        end
        S_GDIV_WAIT: begin
          if (div_done) begin
            chunk_q <= g_chunk;
            state_q <= S_CMUL;
          end
        end
        S_CMUL: begin
          state_q <= S_TAKE;
        end
        S_TAKE: begin
          gstart_q  <= cursor_q;
          gend_q    <= ldisp_pkg::clip_add(cursor_q, mul_q, lt_limit_q);
          cursor_q  <= ldisp_pkg::clip_add(cursor_q, mul_q, lt_limit_q);
          res_idx_q <= cursor_q;
          res_src_q <= ldisp_pkg::SRC_NEW;
          state_q   <= S_GIVE;
        end
        S_SCAN_RD: begin
          if (idx_q == lt_count_q) begin
            if (found_q) begin
              state_q <= S_VIC_RD;
            end else begin
              res_idx_q <= '0;
              res_src_q <= ldisp_pkg::SRC_NONE;
              state_q   <= S_DONE;
            end
          end else begin
            state_q <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (cand && MW'(diff) >= thr_q) begin
            div_start_q    <= 1'b1;
            div_dividend_q <= DW'(diff);
            div_divisor_q  <= lt_stride_q;
            best_q         <= idx_q[AW-1:0];
            state_q        <= S_ITEMS_WAIT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_ITEMS_WAIT: begin
          if (div_done) begin
            most_q  <= div_quot[31:0];
            found_q <= 1'b1;
            state_q <= S_THR;
          end
        end
        S_THR: begin
          thr_q   <= MW'(mul_a) * MW'(lt_stride_q);
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SCAN_RD;
        end
        S_VIC_RD: begin
          state_q <= S_VIC_EV;
        end
        S_VIC_EV: begin
          vnext_q <= ent.nxt;
          vend_q  <= ent.fin;
          chunk_q <= keep;
          state_q <= S_KMUL;
        end
        S_KMUL: begin
          state_q <= S_VIC_WR;
        end
        S_VIC_WR: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= best_q;
          mem_wdata_q <= '{busy: 1'b1,
                           fin: ldisp_pkg::clip_add(vnext_q, mul_q, vend_q),
                           nxt: vnext_q};
          gstart_q    <= ldisp_pkg::clip_add(vnext_q, mul_q, vend_q);
          gend_q      <= vend_q;
          res_idx_q   <= ldisp_pkg::clip_add(vnext_q, mul_q, vend_q);
          res_src_q   <= ldisp_pkg::SRC_STOLEN;
          state_q     <= S_GIVE;
        end
        S_GIVE: begin
          mem_we_q    <= 1'b1;
          mem_waddr_q <= w_q;
          mem_wdata_q <= '{busy: 1'b1,
                           fin: gend_q,
                           nxt: ldisp_pkg::clip_add(gstart_q, MW'(lt_stride_q), gend_q)};
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_src_q     <= res_src_q;
            out_granted_q <= (res_src_q == ldisp_pkg::SRC_OWN) ||
                             (res_src_q == ldisp_pkg::SRC_NEW) ||
                             (res_src_q == ldisp_pkg::SRC_STOLEN);
            out_index_q   <= res_idx_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign granted_o    = out_granted_q;
  assign loop_index_o = out_index_q;
  assign source_o     = out_src_q;

endmodule

// File: rtl/ldisp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldisp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ldisp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ldisp_pkg for default widths.
module ldisp_div #(
  parameter int unsigned DW = ldisp_pkg::DivDW,
  parameter int unsigned VW = ldisp_pkg::DivVW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
